// ===== hdl/kdl_pkg.sv =====
// Shared types and constants of the key debounce and long-press block.
package kdl_pkg;

    localparam int KEY_COUNT_DEF      = 4;
    localparam int STABLE_SAMPLES_DEF = 3;
    localparam int MAX_EVENTS         = 8;

    localparam logic [15:0] LONG_FLOOR_MS  = 16'd100;
    localparam logic [15:0] HOLD_EXTRA_MS  = 16'd500;
    localparam logic [15:0] LONG_RESET_MS  = 16'd1000;
    localparam logic [15:0] HOLD_RESET_MS  = 16'd3000;

    localparam logic REG_LONG_TIME = 1'b0;
    localparam logic REG_HOLD_TIME = 1'b1;

    typedef enum logic [1:0] {
        EV_SHORT = 2'd0,
        EV_LONG  = 2'd1,
        EV_HOLD  = 2'd2
    } event_kind_t;

endpackage

// ===== hdl/key_debounce_long_press.sv =====
// Key debounce with short, long and hold press detection for a bank of keys.
// Each input item is one scan: the raw levels of the keys and a millisecond
// timestamp. The per-key state lives in a small RAM that is read, updated and
// written back one key at a time: each key's entry is read, then processed and
// written back, then each of its events is emitted. A scan is taken in the idle
// state and closes with a flush of the held-back event; the emit and flush
// steps wait while the output is stalled. The state RAM has a registered read.
// Events leave in key order, one per result item; the final one of a scan
// carries last_event. Reset takes effect at once through per-entry valid bits;
// there is no clearing pass. Thresholds are taken at the start of each scan.
module key_debounce_long_press #(
    parameter int KEY_COUNT      = kdl_pkg::KEY_COUNT_DEF,
    parameter int STABLE_SAMPLES = kdl_pkg::STABLE_SAMPLES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  raw_levels,
    input  logic [31:0] now_ms,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  key_index,
    output logic [1:0]  event_kind,
    output logic [3:0]  stable_keys,
    output logic        last_event,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int KEY_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam int CNT_W = $clog2(STABLE_SAMPLES + 1);
    localparam int EVC_W = $clog2(kdl_pkg::MAX_EVENTS + 1);

    typedef struct packed {
        logic             prev;
        logic             stable;
        logic [CNT_W-1:0] cnt;
        logic [31:0]      press;
        logic             long_sent;
        logic             hold_sent;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_PROC,
        S_EMIT,
        S_FLUSH
    } state_t;

    state_t state_reg;

    logic [15:0] long_cfg_reg;
    logic [15:0] hold_cfg_reg;

    logic [3:0]       levels_reg;
    logic [31:0]      now_reg;
    logic [15:0]      lg_reg;
    logic [15:0]      hd_reg;
    logic [KEY_W-1:0] key_reg;
    logic [KEY_COUNT-1:0] valid_reg;
    logic [3:0]       stable_reg;
    logic [EVC_W-1:0] evc_reg;

    // Events of the key in hand: the first is short or long, the second hold.
    logic              eva_valid_reg;
    kdl_pkg::event_kind_t eva_kind_reg;
    logic              evb_valid_reg;

    // One event is held back until the next one or the end of the scan,
    // so that the final event of a scan can be marked.
    logic              pend_valid_reg;
    logic [1:0]        pend_key_reg;
    kdl_pkg::event_kind_t pend_kind_reg;
    logic [3:0]        pend_stable_reg;

    logic              out_valid_reg;
    logic [1:0]        out_key_reg;
    kdl_pkg::event_kind_t out_kind_reg;
    logic [3:0]        out_stable_reg;
    logic              out_last_reg;

    logic [15:0]  lg_eff;
    logic [15:0]  hd_eff;
    logic [ENTRY_W-1:0] rd_data;
    entry_t       ent;
    entry_t       ent_next;
    logic         raw_bit;
    logic [31:0]  held;
    logic         eva_next;
    kdl_pkg::event_kind_t eva_kind_next;
    logic         evb_next;
    logic [3:0]   stable_next;
    logic [1:0]   key_idx2;
    logic         out_free;
    logic         last_key;
    logic         out_load;

    // Effective thresholds after the setter's clamps.
    always_comb
    begin
        lg_eff = (long_cfg_reg < kdl_pkg::LONG_FLOOR_MS) ? kdl_pkg::LONG_FLOOR_MS : long_cfg_reg;
        hd_eff = (hold_cfg_reg < lg_eff) ? (lg_eff + kdl_pkg::HOLD_EXTRA_MS) : hold_cfg_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_cfg_reg <= kdl_pkg::LONG_RESET_MS;
            hold_cfg_reg <= kdl_pkg::HOLD_RESET_MS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                kdl_pkg::REG_LONG_TIME: long_cfg_reg <= cfg_data;
                kdl_pkg::REG_HOLD_TIME: hold_cfg_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    kdl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (KEY_COUNT),
        .AW    (KEY_W)
    ) u_state_ram (
        .clk   (clk),
        .we    (state_reg == S_PROC),
        .waddr (key_reg),
        .wdata (ent_next),
        .re    (state_reg == S_READ),
        .raddr (key_reg),
        .rdata (rd_data)
    );

    // Update of one key's entry from its stored state and this scan's level.
    always_comb
    begin
        raw_bit = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            if (32'(key_reg) == i)
            begin
                raw_bit = levels_reg[i];
            end
        end

        ent = valid_reg[key_reg] ? entry_t'(rd_data) : '0;
        ent_next = ent;
        ent_next.prev = raw_bit;
        if (raw_bit == ent.prev)
        begin
            if (ent.cnt < CNT_W'(STABLE_SAMPLES))
            begin
                ent_next.cnt = ent.cnt + 1'b1;
            end
        end
        else
        begin
            ent_next.cnt = '0;
        end

        held          = now_reg - ent.press;
        eva_next      = 1'b0;
        eva_kind_next = kdl_pkg::EV_SHORT;
        evb_next      = 1'b0;
        stable_next   = stable_reg;

        if (ent_next.cnt >= CNT_W'(STABLE_SAMPLES))
        begin
            if (ent.stable != raw_bit)
            begin
                ent_next.stable = raw_bit;
                for (int i = 0; i < 4; i++)
                begin
                    if (32'(key_reg) == i)
                    begin
                        stable_next[i] = raw_bit;
                    end
                end
                if (raw_bit)
                begin
                    ent_next.press     = now_reg;
                    ent_next.long_sent = 1'b0;
                    ent_next.hold_sent = 1'b0;
                end
                else if (!ent.long_sent && (held < {16'd0, lg_reg}))
                begin
                    eva_next = 1'b1;
                end
            end
            else if (ent.stable)
            begin
                if (!ent.long_sent && (held >= {16'd0, lg_reg}))
                begin
                    ent_next.long_sent = 1'b1;
                    eva_next           = 1'b1;
                    eva_kind_next      = kdl_pkg::EV_LONG;
                end
                if (!ent.hold_sent && (held >= {16'd0, hd_reg}))
                begin
                    ent_next.hold_sent = 1'b1;
                    evb_next           = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        key_idx2 = 2'(key_reg);
        out_free = !out_valid_reg || out_ready;
        last_key = (key_reg == KEY_W'(KEY_COUNT - 1));
        // The output register takes the held-back event in this cycle.
        out_load = 1'b0;
        if (state_reg == S_EMIT)
        begin
            out_load = (eva_valid_reg || evb_valid_reg)
                       && (evc_reg < EVC_W'(kdl_pkg::MAX_EVENTS))
                       && pend_valid_reg && out_free;
        end
        else if (state_reg == S_FLUSH)
        begin
            out_load = pend_valid_reg && out_free;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            key_reg        <= '0;
            valid_reg      <= '0;
            stable_reg     <= '0;
            evc_reg        <= '0;
            eva_valid_reg  <= 1'b0;
            evb_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        levels_reg <= raw_levels;
                        now_reg    <= now_ms;
                        lg_reg     <= lg_eff;
                        hd_reg     <= hd_eff;
                        key_reg    <= '0;
                        evc_reg    <= '0;
                        state_reg  <= S_READ;
                    end
                end

                S_READ:
                begin
                    state_reg <= S_PROC;
                end

                S_PROC:
                begin
                    valid_reg[key_reg] <= 1'b1;
                    stable_reg         <= stable_next;
                    eva_valid_reg      <= eva_next;
                    eva_kind_reg       <= eva_kind_next;
                    evb_valid_reg      <= evb_next;
                    state_reg          <= S_EMIT;
                end

                S_EMIT:
                begin
                    if (eva_valid_reg || evb_valid_reg)
                    begin
                        if (evc_reg >= EVC_W'(kdl_pkg::MAX_EVENTS))
                        begin
                            // Beyond the per-scan limit the event is dropped.
                            eva_valid_reg <= 1'b0;
                            evb_valid_reg <= 1'b0;
                        end
                        else if (!pend_valid_reg || out_free)
                        begin
                            if (pend_valid_reg)
                            begin
                                out_key_reg    <= pend_key_reg;
                                out_kind_reg   <= pend_kind_reg;
                                out_stable_reg <= pend_stable_reg;
                                out_last_reg   <= 1'b0;
                            end
                            pend_valid_reg  <= 1'b1;
                            pend_key_reg    <= key_idx2;
                            pend_stable_reg <= stable_reg;
                            evc_reg         <= evc_reg + 1'b1;
                            if (eva_valid_reg)
                            begin
                                pend_kind_reg <= eva_kind_reg;
                                eva_valid_reg <= 1'b0;
                            end
                            else
                            begin
                                pend_kind_reg <= kdl_pkg::EV_HOLD;
                                evb_valid_reg <= 1'b0;
                            end
                        end
                    end
                    else if (last_key)
                    begin
                        state_reg <= S_FLUSH;
                    end
                    else
                    begin
                        key_reg   <= key_reg + 1'b1;
                        state_reg <= S_READ;
                    end
                end

                S_FLUSH:
                begin
                    if (!pend_valid_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (out_free)
                    begin
                        out_key_reg    <= pend_key_reg;
                        out_kind_reg   <= pend_kind_reg;
                        out_stable_reg <= pend_stable_reg;
                        out_last_reg   <= 1'b1;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign key_index   = out_key_reg;
    assign event_kind  = out_kind_reg;
    assign stable_keys = out_stable_reg;
    assign last_event  = out_last_reg;

endmodule

// ===== hdl/kdl_ram.sv =====
// Generic single-port-write, registered-read RAM.
module kdl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/kdl_checker.sv =====
// Port-level checks of the key debounce block, bound to its top level.
module kdl_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] key_index,
    input logic [1:0] event_kind,
    input logic [3:0] stable_keys,
    input logic       last_event
);

    // A stalled item stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result item withdrawn while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable({key_index, event_kind, stable_keys, last_event}))
        else $error("result item changed while stalled");

    // A scan is worked on alone: the block is busy in the cycle after it takes one.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second scan taken while the first is in progress");

    // A short press is reported after release, long and hold while pressed.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_kind == kdl_pkg::EV_SHORT) |-> !stable_keys[key_index])
        else $error("short press reported while the key reads pressed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((event_kind == kdl_pkg::EV_LONG) || (event_kind == kdl_pkg::EV_HOLD))
        |-> stable_keys[key_index])
        else $error("long or hold reported while the key reads released");

endmodule

bind key_debounce_long_press kdl_checker u_kdl_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .key_index   (key_index),
    .event_kind  (event_kind),
    .stable_keys (stable_keys),
    .last_event  (last_event)
);

// ===== test/kdl_event_checker.sv =====
// Checker that predicts the press events of the key debounce block and compares them.
module kdl_event_checker
    import kdl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [3:0]  raw_levels,
    input  logic [31:0] now_ms,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [1:0]  key_index,
    input  logic [1:0]  event_kind,
    input  logic [3:0]  stable_keys,
    input  logic        last_event,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          pending
);

    typedef struct {
        logic [1:0]  key;
        event_kind_t kind;
        logic [3:0]  keys;
        logic        last;
    } press_event_t;

    logic [3:0]  prev_raw;
    logic [3:0]  stable_lvl;
    logic [3:0]  long_done;
    logic [3:0]  hold_done;
    logic [1:0]  same_cnt [4];
    logic [31:0] press_ms [4];
    logic [15:0] long_cfg;
    logic [15:0] hold_cfg;

    press_event_t awaited_events[$];
    int errors = 0;

    // Works out the events of one scan and queues them in the order they leave the block.
    task automatic predict_scan(input logic [3:0] lv, input logic [31:0] t);
        press_event_t evs [MAX_EVENTS];
        int n;
        int k;
        logic [31:0] lg;
        logic [31:0] hd;
        logic [31:0] held;
        logic [15:0] hold_wrap;
        n = 0;
        lg = (long_cfg < LONG_FLOOR_MS) ? {16'd0, LONG_FLOOR_MS} : {16'd0, long_cfg};
        hd = {16'd0, hold_cfg};
        if (hd < lg)
        begin
            // The fallback hold threshold wraps at 16 bits.
            hold_wrap = lg[15:0] + HOLD_EXTRA_MS;
            hd = {16'd0, hold_wrap};
        end
        for (k = 0; k < 4; k++)
        begin
            if (lv[k] == prev_raw[k])
            begin
                if (same_cnt[k] < STABLE_SAMPLES_DEF)
                    same_cnt[k] = same_cnt[k] + 2'd1;
            end
            else
                same_cnt[k] = 2'd0;
            prev_raw[k] = lv[k];
            held = t - press_ms[k];
            if (same_cnt[k] >= STABLE_SAMPLES_DEF)
            begin
                if (stable_lvl[k] != lv[k])
                begin
                    stable_lvl[k] = lv[k];
                    if (lv[k])
                    begin
                        press_ms[k] = t;
                        long_done[k] = 1'b0;
                        hold_done[k] = 1'b0;
                    end
                    else if (!long_done[k] && held < lg && n < MAX_EVENTS)
                    begin
                        evs[n] = '{key: 2'(k), kind: EV_SHORT, keys: stable_lvl, last: 1'b0};
                        n++;
                    end
                end
                else if (stable_lvl[k])
                begin
                    if (!long_done[k] && held >= lg)
                    begin
                        long_done[k] = 1'b1;
                        if (n < MAX_EVENTS)
                        begin
                            evs[n] = '{key: 2'(k), kind: EV_LONG, keys: stable_lvl, last: 1'b0};
                            n++;
                        end
                    end
                    if (!hold_done[k] && held >= hd)
                    begin
                        hold_done[k] = 1'b1;
                        if (n < MAX_EVENTS)
                        begin
                            evs[n] = '{key: 2'(k), kind: EV_HOLD, keys: stable_lvl, last: 1'b0};
                            n++;
                        end
                    end
                end
            end
        end
        if (n > 0)
            evs[n - 1].last = 1'b1;
        for (k = 0; k < n; k++)
            awaited_events.push_back(evs[k]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        press_event_t want;
        if (!rst_n)
        begin
            prev_raw = '0;
            stable_lvl = '0;
            long_done = '0;
            hold_done = '0;
            for (int k = 0; k < 4; k++)
            begin
                same_cnt[k] = 2'd0;
                press_ms[k] = 32'd0;
            end
            long_cfg = LONG_RESET_MS;
            hold_cfg = HOLD_RESET_MS;
            awaited_events.delete();
            pending <= 0;
            fail_count <= errors;
        end
        else
        begin
            // Results are checked before this edge's scan is predicted, since a scan
            // cannot produce an event at the edge where it is taken.
            if (out_valid && out_ready)
            begin
                if (awaited_events.size() == 0)
                begin
                    $error("unexpected event item: key_index %0d event_kind %0d",
                           key_index, event_kind);
                    errors++;
                end
                else
                begin
                    want = awaited_events.pop_front();
                    if (key_index !== want.key)
                    begin
                        $error("key_index: expected %0d, got %0d", want.key, key_index);
                        errors++;
                    end
                    if (event_kind !== want.kind)
                    begin
                        $error("event_kind: expected %0d, got %0d", want.kind, event_kind);
                        errors++;
                    end
                    if (stable_keys !== want.keys)
                    begin
                        $error("stable_keys: expected %b, got %b", want.keys, stable_keys);
                        errors++;
                    end
                    if (last_event !== want.last)
                    begin
                        $error("last_event: expected %0d, got %0d", want.last, last_event);
                        errors++;
                    end
                end
            end
            if (in_valid && in_ready)
                predict_scan(raw_levels, now_ms);
            if (cfg_we)
            begin
                if (cfg_index == REG_LONG_TIME)
                    long_cfg = cfg_data;
                else if (cfg_index == REG_HOLD_TIME)
                    hold_cfg = cfg_data;
            end
            pending <= awaited_events.size();
            fail_count <= errors;
        end
    end

endmodule

// ===== test/tb.sv =====
// Top of the key debounce testbench: clock, reset, scan stimulus and the verdict.
module tb;
    import kdl_pkg::*;

    localparam int SETTLE_CYCLES   = 40;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int SCANS_PER_PHASE = 45;
    localparam int PHASES          = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [3:0]  raw_levels = 4'd0;
    logic [31:0] now_ms = 32'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  key_index;
    logic [1:0]  event_kind;
    logic [3:0]  stable_keys;
    logic        last_event;
    logic        cfg_we = 1'b0;
    logic        cfg_index = REG_LONG_TIME;
    logic [15:0] cfg_data = 16'd0;

    int   fail_count;
    int   pending;
    int   cycles = 0;
    int   rx_hold_off = 0;
    bit   tx_quiet = 1'b0;
    bit   rx_quiet = 1'b0;
    logic [3:0] key_plan = 4'd0;

    key_debounce_long_press dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .raw_levels (raw_levels),
        .now_ms     (now_ms),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .key_index  (key_index),
        .event_kind (event_kind),
        .stable_keys(stable_keys),
        .last_event (last_event),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    kdl_event_checker events_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .raw_levels (raw_levels),
        .now_ms     (now_ms),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .key_index  (key_index),
        .event_kind (event_kind),
        .stable_keys(stable_keys),
        .last_event (last_event),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Event sink: after each item, unless rx_quiet, holds ready low for a random stretch.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_hold_off = 0;
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
                rx_hold_off = rx_quiet ? 0 : $urandom_range(0, 15);
            else if (rx_hold_off > 0)
                rx_hold_off--;
            out_ready <= (rx_hold_off == 0);
        end
    end

    // Called at a rising edge; returns at the edge where the scan item is taken.
    task automatic send_scan(input logic [3:0] lv, input logic [31:0] t);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        raw_levels <= lv;
        now_ms <= t;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic wait_for_quiet();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_thresholds(input logic [15:0] long_ms, input logic [15:0] hold_ms);
        cfg_we <= 1'b1;
        cfg_index <= REG_LONG_TIME;
        cfg_data <= long_ms;
        @(posedge clk);
        cfg_index <= REG_HOLD_TIME;
        cfg_data <= hold_ms;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic directed_scans();
        logic [31:0] t;
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        // All keys pressed just before the timestamp wraps, released just after it.
        t = 32'hFFFF_FF00;
        repeat (4)
        begin
            send_scan(4'hF, t);
            t = t + 32'd10;
        end
        repeat (4)
        begin
            send_scan(4'h0, t);
            t = t + 32'd100;
        end
        // A long gap lets every key report long and hold in one scan.
        t = 32'h7FFF_0000;
        repeat (4)
        begin
            send_scan(4'hF, t);
            t = t + 32'd20;
        end
        t = t + 32'd5000;
        send_scan(4'hF, t);
        repeat (4)
        begin
            send_scan(4'h0, t);
            t = t + 32'd20;
        end
        // One key held to exactly the long threshold, one millisecond short of it first.
        repeat (3)
        begin
            send_scan(4'h1, t);
            t = t + 32'd20;
        end
        send_scan(4'h1, t);
        send_scan(4'h1, t + 32'd999);
        send_scan(4'h1, t + 32'd1000);
        key_plan = 4'h1;
    endtask

    task automatic run_phase(input int p);
        logic [15:0] long_ms;
        logic [15:0] hold_ms;
        logic [31:0] t;
        logic [31:0] step_max;
        logic [3:0]  lv;
        case (p)
            0: begin long_ms = 16'd0;     hold_ms = 16'd0;     end
            1: begin long_ms = 16'd99;    hold_ms = 16'd150;   end
            2: begin long_ms = 16'd100;   hold_ms = 16'd100;   end
            3: begin long_ms = 16'hFFFF;  hold_ms = 16'hFFFF;  end
            // The fallback hold threshold wraps below the long one.
            4: begin long_ms = 16'd65300; hold_ms = 16'd0;     end
            5:
            begin
                long_ms = 16'($urandom_range(100, 600));
                hold_ms = 16'($urandom_range(0, 1500));
            end
            6: begin long_ms = 16'd300;   hold_ms = 16'd299;   end
            default: begin long_ms = LONG_RESET_MS; hold_ms = HOLD_RESET_MS; end
        endcase
        in_valid <= 1'b0;
        wait_for_quiet();
        write_thresholds(long_ms, hold_ms);
        tx_quiet = (p % 3 == 1);
        rx_quiet = (p % 4 == 2);
        step_max = ((long_ms < 16'd100) ? 32'd100 : {16'd0, long_ms}) / 3 + 32'd10;
        t = (p == 4) ? 32'hFFFF_FFFF - $urandom_range(0, 20000) : $urandom();
        repeat (SCANS_PER_PHASE)
        begin
            if ($urandom_range(0, 11) == 0)
            begin
                // Noise: an arbitrary pattern at an arbitrary time.
                lv = 4'($urandom());
                t = $urandom();
            end
            else
            begin
                for (int k = 0; k < 4; k++)
                begin
                    if ($urandom_range(0, 5) == 0)
                        key_plan[k] = ~key_plan[k];
                    lv[k] = key_plan[k] ^ ($urandom_range(0, 9) == 0);
                end
                t = t + $urandom_range(1, step_max);
            end
            send_scan(lv, t);
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_scans();
        for (int p = 0; p < PHASES; p++)
            run_phase(p);
        in_valid <= 1'b0;
        wait_for_quiet();
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/kdl_pkg.sv
hdl/kdl_ram.sv
hdl/key_debounce_long_press.sv
hdl/kdl_checker.sv
test/kdl_event_checker.sv
test/tb.sv
